// ----- src/led_status_pattern_generator_defines.svh -----
// Assertion macros used by the pattern generator to check itself.
`ifndef LED_STATUS_PATTERN_GENERATOR_DEFINES_SVH
`define LED_STATUS_PATTERN_GENERATOR_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define LSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led status pattern generator: check failed");

// Checks that a consequent holds the given delay after its antecedent.
`define LSP_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("led status pattern generator: timing check failed");

`endif

// ----- src/lsp_pkg.sv -----
package lsp_pkg;

    // Status codes.
    localparam logic [3:0] ST_GENERATING  = 4'd0;
    localparam logic [3:0] ST_DOWNLOADING = 4'd1;
    localparam logic [3:0] ST_CACHING     = 4'd2;
    localparam logic [3:0] ST_CONVERTING  = 4'd3;
    localparam logic [3:0] ST_WRITING     = 4'd4;
    localparam logic [3:0] ST_COMPLETE    = 4'd5;
    localparam logic [3:0] ST_ERROR       = 4'd6;
    localparam logic [3:0] ST_OFF         = 4'd7;

    localparam int CODE_W    = 4;
    localparam int ELAPSED_W = 32;
    localparam int CH_W      = 8;

    // Modulo unit: period = 2^shift * m, with m in {25, 75, 125} and shift >= 2.
    localparam int MOD_X_W   = 30;
    localparam int MOD_R_W   = 28;
    localparam int MOD_SH    = 32;
    localparam int MOD_Q_W   = MOD_X_W + MOD_R_W - MOD_SH;
    localparam int MOD_M_W   = 7;
    localparam int MOD_K_W   = 3;
    localparam int REM_W     = 8;
    localparam int LOW_W     = 5;
    localparam int PHASE_W   = 11;

    // Triangle wave and its division by the half period.
    localparam int RISE_W    = 10;
    localparam int NUM_W     = 18;
    localparam int HREC_W    = 20;
    localparam int HREC_SH   = 28;

    // Channel scaling: (c * s + 127) / 255, done as a multiply by a reciprocal.
    localparam int SCL_W     = 16;
    localparam int SCL_K_W   = 16;
    localparam int SCL_SH    = 23;
    localparam logic [SCL_W-1:0]   SCL_ROUND = 16'd127;
    localparam logic [SCL_K_W-1:0] SCL_RECIP = 16'd32897;
    localparam logic [CH_W-1:0]    FULL_BRIGHT = 8'd255;

    // Blink and timeout limits in milliseconds.
    localparam logic [PHASE_W-1:0]   WR_ON_MS = 11'd250;
    localparam logic [ELAPSED_W-1:0] DONE_MS  = 32'd2000;
    localparam logic [ELAPSED_W-1:0] ERR_STEP = 32'd200;

    // Cycles from an accepted beat to its result strobe.
    localparam int LATENCY = 10;

    typedef struct packed {
        logic [3:0]  led_state;
        logic [31:0] now_ms;
        logic [31:0] state_start_ms;
    } lsp_in_t;

    typedef struct packed {
        logic       recognized;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       lit;
    } lsp_out_t;

    // Status facts that travel alongside the modulo unit.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              done_on;
        logic              err_on;
    } lsp_side_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } lsp_rgb_t;

    function automatic logic [MOD_K_W-1:0] mod_shift(input logic [CODE_W-1:0] code);
        logic [MOD_K_W-1:0] k;
        case (code)
            ST_GENERATING:  k = 3'd4;
            ST_DOWNLOADING: k = 3'd3;
            ST_CACHING:     k = 3'd5;
            ST_CONVERTING:  k = 3'd3;
            default:        k = 3'd2;
        endcase
        return k;
    endfunction

    function automatic logic [MOD_M_W-1:0] mod_div(input logic [CODE_W-1:0] code);
        logic [MOD_M_W-1:0] m;
        case (code)
            ST_DOWNLOADING: m = 7'd75;
            ST_CACHING:     m = 7'd25;
            default:        m = 7'd125;
        endcase
        return m;
    endfunction

    // floor(2^32 / m) for the odd factor of the period.
    function automatic logic [MOD_R_W-1:0] mod_recip(input logic [CODE_W-1:0] code);
        logic [MOD_R_W-1:0] r;
        case (code)
            ST_DOWNLOADING: r = 28'd57266230;
            ST_CACHING:     r = 28'd171798691;
            default:        r = 28'd34359738;
        endcase
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] period(input logic [CODE_W-1:0] code);
        logic [PHASE_W-1:0] p;
        case (code)
            ST_GENERATING:  p = 11'd2000;
            ST_DOWNLOADING: p = 11'd600;
            ST_CACHING:     p = 11'd800;
            ST_CONVERTING:  p = 11'd1000;
            default:        p = 11'd500;
        endcase
        return p;
    endfunction

    // ceil(2^28 / half period); exact for numerators below 2^18.
    function automatic logic [HREC_W-1:0] half_recip(input logic [CODE_W-1:0] code);
        logic [HREC_W-1:0] r;
        case (code)
            ST_GENERATING:  r = 20'd268436;
            ST_DOWNLOADING: r = 20'd894785;
            ST_CACHING:     r = 20'd671089;
            default:        r = 20'd536871;
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] bright_floor(input logic [CODE_W-1:0] code);
        logic [CH_W-1:0] f;
        case (code)
            ST_GENERATING: f = 8'd48;
            ST_CONVERTING: f = 8'd56;
            default:       f = 8'd64;
        endcase
        return f;
    endfunction

    function automatic lsp_rgb_t color(input logic [CODE_W-1:0] code);
        lsp_rgb_t c;
        case (code)
            ST_GENERATING:  c = '{r: 8'd0,   g: 8'd255, b: 8'd60};
            ST_DOWNLOADING: c = '{r: 8'd0,   g: 8'd90,  b: 8'd255};
            ST_CACHING:     c = '{r: 8'd255, g: 8'd190, b: 8'd0};
            ST_CONVERTING:  c = '{r: 8'd0,   g: 8'd220, b: 8'd160};
            ST_WRITING:     c = '{r: 8'd255, g: 8'd120, b: 8'd0};
            ST_COMPLETE:    c = '{r: 8'd0,   g: 8'd255, b: 8'd60};
            ST_ERROR:       c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
            default:        c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
        endcase
        return c;
    endfunction

endpackage

// ----- src/lsp_phase.sv -----
// Three-stage modulo unit: phase = elapsed mod period(code).
// The period is split into 2^k * m; the odd part is reduced by a reciprocal
// multiply followed by one conditional subtract.
module lsp_phase
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  lsp_pkg::lsp_side_t                  in_side,
    input  logic [lsp_pkg::ELAPSED_W-1:0]       in_elapsed,
    output logic                                out_valid,
    output lsp_pkg::lsp_side_t                  out_side,
    output logic [lsp_pkg::PHASE_W-1:0]         out_phase
);

    localparam int PROD_W = lsp_pkg::MOD_X_W + lsp_pkg::MOD_R_W;

    // Stage 1: quotient estimate.
    logic                           v1_reg;
    lsp_pkg::lsp_side_t             side1_reg;
    logic [lsp_pkg::MOD_X_W-1:0]    x1_reg, x1_next;
    logic [lsp_pkg::MOD_Q_W-1:0]    q1_reg, q1_next;
    logic [lsp_pkg::LOW_W-1:0]      low1_reg;
    logic [PROD_W-1:0]              prod1;

    // Stage 2: raw remainder, below twice the divisor.
    logic                           v2_reg;
    lsp_pkg::lsp_side_t             side2_reg;
    logic [lsp_pkg::REM_W-1:0]      rem2_reg, rem2_next;
    logic [lsp_pkg::LOW_W-1:0]      low2_reg;
    logic [lsp_pkg::MOD_X_W-1:0]    qm2;

    // Stage 3: corrected remainder put back together with the low bits.
    logic                           v3_reg;
    lsp_pkg::lsp_side_t             side3_reg;
    logic [lsp_pkg::PHASE_W-1:0]    phase3_reg, phase3_next;
    logic [lsp_pkg::REM_W-1:0]      m3, r3;
    logic [lsp_pkg::MOD_K_W-1:0]    k3;
    logic [lsp_pkg::PHASE_W-1:0]    mask3;

    always_comb
    begin
        x1_next = lsp_pkg::MOD_X_W'(in_elapsed >> lsp_pkg::mod_shift(in_side.code));
        prod1   = PROD_W'(x1_next) * PROD_W'(lsp_pkg::mod_recip(in_side.code));
        q1_next = prod1[PROD_W-1 -: lsp_pkg::MOD_Q_W];
    end

    always_comb
    begin
        qm2 = lsp_pkg::MOD_X_W'(lsp_pkg::MOD_X_W'(q1_reg)
                                * lsp_pkg::MOD_X_W'(lsp_pkg::mod_div(side1_reg.code)));
        rem2_next = lsp_pkg::REM_W'(x1_reg - qm2);
    end

    always_comb
    begin
        m3 = lsp_pkg::REM_W'(lsp_pkg::mod_div(side2_reg.code));
        k3 = lsp_pkg::mod_shift(side2_reg.code);
        r3 = (rem2_reg >= m3) ? (rem2_reg - m3) : rem2_reg;
        mask3 = (lsp_pkg::PHASE_W'(1) << k3) - lsp_pkg::PHASE_W'(1);
        phase3_next = (lsp_pkg::PHASE_W'(r3) << k3) | (lsp_pkg::PHASE_W'(low2_reg) & mask3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg  <= in_side;
        x1_reg     <= x1_next;
        q1_reg     <= q1_next;
        low1_reg   <= in_elapsed[lsp_pkg::LOW_W-1:0];
        side2_reg  <= side1_reg;
        rem2_reg   <= rem2_next;
        low2_reg   <= low1_reg;
        side3_reg  <= side2_reg;
        phase3_reg <= phase3_next;
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign out_phase = phase3_reg;

endmodule

// ----- src/led_status_pattern_generator.sv -----
// Status LED pattern generator.
//
// A beat is offered on item (status code, current time and the time the
// status began, all in milliseconds) and is taken at a rising edge where
// start is high and busy is low. busy never rises: the pipeline takes a new
// beat in every cycle, so one result per cycle is the sustained rate.
// Each beat gives exactly one result on result, marked by a one-cycle done
// strobe once the beat has passed every register stage. Results leave in
// the order their beats arrived. The receiver cannot stall; the pipeline
// never holds, so nothing is lost or repeated.
// The depth is set by the modulo of the elapsed time (reciprocal multiply,
// remainder, correction), the triangle division by the half period and the
// per-channel brightness scaling, each split over its own register stages.
// Reset clears the valid bits of every stage, so no strobe appears until a
// beat is accepted after reset; payload registers are not reset.

`include "led_status_pattern_generator_defines.svh"

module led_status_pattern_generator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lsp_pkg::lsp_in_t    item,
    output logic                done,
    output lsp_pkg::lsp_out_t   result
);

    // Control that travels with a beat after the phase is known.
    typedef struct packed {
        logic [lsp_pkg::CODE_W-1:0] code;
        logic                       lit;
        logic                       rec;
    } ctl_t;

    localparam int HPROD_W = lsp_pkg::NUM_W + lsp_pkg::HREC_W;
    localparam int SPROD_W = lsp_pkg::SCL_W + lsp_pkg::SCL_K_W;

    // Stage 1: elapsed time, modulo 2^32.
    logic                               v1_reg;
    logic [lsp_pkg::CODE_W-1:0]         code1_reg;
    logic [lsp_pkg::ELAPSED_W-1:0]      e1_reg;
    lsp_pkg::lsp_side_t                 side1;

    // Stages 2 to 4 live in the modulo unit.
    logic                               v4;
    lsp_pkg::lsp_side_t                 side4;
    logic [lsp_pkg::PHASE_W-1:0]        phase4;

    // Stage 5: triangle rise and the lit decision.
    logic                               v5_reg;
    ctl_t                               ctl5_reg, ctl5_next;
    logic [lsp_pkg::RISE_W-1:0]         rise5_reg, rise5_next;
    logic [lsp_pkg::PHASE_W-1:0]        per5;
    logic [lsp_pkg::PHASE_W-1:0]        half5;

    // Stage 6: (255 - floor) * rise.
    logic                               v6_reg;
    ctl_t                               ctl6_reg;
    logic [lsp_pkg::NUM_W-1:0]          num6_reg, num6_next;

    // Stage 7: quotient by the half period.
    logic                               v7_reg;
    ctl_t                               ctl7_reg;
    logic [lsp_pkg::CH_W-1:0]           qd7_reg, qd7_next;
    logic [HPROD_W-1:0]                 hprod7;

    // Stage 8: brightness.
    logic                               v8_reg;
    ctl_t                               ctl8_reg;
    logic [lsp_pkg::CH_W-1:0]           s8_reg, s8_next;

    // Stage 9: c * s + 127 per channel.
    logic                               v9_reg;
    ctl_t                               ctl9_reg;
    logic [lsp_pkg::SCL_W-1:0]          xr9_reg, xg9_reg, xb9_reg;
    logic [lsp_pkg::SCL_W-1:0]          xr9_next, xg9_next, xb9_next;
    lsp_pkg::lsp_rgb_t                  col9;

    // Stage 10: division by 255 and the output register.
    logic                               done_reg;
    lsp_pkg::lsp_out_t                  result_reg, result_next;
    logic [SPROD_W-1:0]                 pr10, pg10, pb10;

    // The pipeline never holds, so a beat is always welcome.
    assign busy = 1'b0;

    // Completion and error windows need only the elapsed time, so they are
    // decided here and ride beside the modulo unit.
    always_comb
    begin
        side1.code    = code1_reg;
        side1.done_on = (e1_reg < lsp_pkg::DONE_MS);
        // Error blinks on the even 200 ms slots of its first 1.2 s.
        side1.err_on  = (e1_reg < lsp_pkg::ERR_STEP)
                     || ((e1_reg >= 2 * lsp_pkg::ERR_STEP) && (e1_reg < 3 * lsp_pkg::ERR_STEP))
                     || ((e1_reg >= 4 * lsp_pkg::ERR_STEP) && (e1_reg < 5 * lsp_pkg::ERR_STEP));
    end

    lsp_phase u_phase
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg),
        .in_side    (side1),
        .in_elapsed (e1_reg),
        .out_valid  (v4),
        .out_side   (side4),
        .out_phase  (phase4)
    );

    // The rise folds the phase back down after the half period. For the
    // writing status the same phase is the position inside its 500 ms blink.
    always_comb
    begin
        per5  = lsp_pkg::period(side4.code);
        half5 = per5 >> 1;
        if (phase4 <= half5)
        begin
            rise5_next = lsp_pkg::RISE_W'(phase4);
        end
        else
        begin
            rise5_next = lsp_pkg::RISE_W'(per5 - phase4);
        end
        ctl5_next.code = side4.code;
        ctl5_next.rec  = (side4.code <= lsp_pkg::ST_OFF);
        case (side4.code) inside
            [lsp_pkg::ST_GENERATING:lsp_pkg::ST_CONVERTING]: ctl5_next.lit = 1'b1;
            lsp_pkg::ST_WRITING:  ctl5_next.lit = (phase4 < lsp_pkg::WR_ON_MS);
            lsp_pkg::ST_COMPLETE: ctl5_next.lit = side4.done_on;
            lsp_pkg::ST_ERROR:    ctl5_next.lit = side4.err_on;
            default:              ctl5_next.lit = 1'b0;
        endcase
    end

    always_comb
    begin
        num6_next = lsp_pkg::NUM_W'(lsp_pkg::FULL_BRIGHT - lsp_pkg::bright_floor(ctl5_reg.code))
                  * lsp_pkg::NUM_W'(rise5_reg);
    end

    // Exact quotient: the reciprocal is rounded up with enough spare bits.
    always_comb
    begin
        hprod7   = HPROD_W'(num6_reg) * HPROD_W'(lsp_pkg::half_recip(ctl6_reg.code));
        qd7_next = hprod7[lsp_pkg::HREC_SH +: lsp_pkg::CH_W];
    end

    // Blinking and solid statuses run at full brightness, which leaves the
    // color unchanged through the scaling below.
    always_comb
    begin
        if (ctl7_reg.code <= lsp_pkg::ST_CONVERTING)
        begin
            s8_next = lsp_pkg::bright_floor(ctl7_reg.code) + qd7_reg;
        end
        else
        begin
            s8_next = lsp_pkg::FULL_BRIGHT;
        end
    end

    always_comb
    begin
        col9     = lsp_pkg::color(ctl8_reg.code);
        xr9_next = lsp_pkg::SCL_W'(col9.r) * lsp_pkg::SCL_W'(s8_reg) + lsp_pkg::SCL_ROUND;
        xg9_next = lsp_pkg::SCL_W'(col9.g) * lsp_pkg::SCL_W'(s8_reg) + lsp_pkg::SCL_ROUND;
        xb9_next = lsp_pkg::SCL_W'(col9.b) * lsp_pkg::SCL_W'(s8_reg) + lsp_pkg::SCL_ROUND;
    end

    // x / 255 for 16-bit x is (x * 32897) >> 23; a dark LED shows zeros.
    always_comb
    begin
        pr10 = SPROD_W'(xr9_reg) * SPROD_W'(lsp_pkg::SCL_RECIP);
        pg10 = SPROD_W'(xg9_reg) * SPROD_W'(lsp_pkg::SCL_RECIP);
        pb10 = SPROD_W'(xb9_reg) * SPROD_W'(lsp_pkg::SCL_RECIP);
        result_next.recognized = ctl9_reg.rec;
        result_next.lit        = ctl9_reg.lit;
        if (ctl9_reg.lit)
        begin
            result_next.red   = pr10[lsp_pkg::SCL_SH +: lsp_pkg::CH_W];
            result_next.green = pg10[lsp_pkg::SCL_SH +: lsp_pkg::CH_W];
            result_next.blue  = pb10[lsp_pkg::SCL_SH +: lsp_pkg::CH_W];
        end
        else
        begin
            result_next.red   = '0;
            result_next.green = '0;
            result_next.blue  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v5_reg   <= v4;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            done_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        code1_reg  <= item.led_state;
        e1_reg     <= item.now_ms - item.state_start_ms;
        ctl5_reg   <= ctl5_next;
        rise5_reg  <= rise5_next;
        ctl6_reg   <= ctl5_reg;
        num6_reg   <= num6_next;
        ctl7_reg   <= ctl6_reg;
        qd7_reg    <= qd7_next;
        ctl8_reg   <= ctl7_reg;
        s8_reg     <= s8_next;
        ctl9_reg   <= ctl8_reg;
        xr9_reg    <= xr9_next;
        xg9_reg    <= xg9_next;
        xb9_reg    <= xb9_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted beat produces its strobe after the pipeline depth.
    `LSP_ASSERT_AFTER(a_beat_to_done, clk, rst_n, start && !busy, lsp_pkg::LATENCY, done)
    // No strobe without a beat accepted the pipeline depth before.
    `LSP_ASSERT_NOW(a_done_has_beat, clk, rst_n, done, $past(start && !busy, lsp_pkg::LATENCY))
    // A dark LED carries no color.
    `LSP_ASSERT_NOW(a_dark_is_black, clk, rst_n, done && !result.lit,
                    (result.red == '0) && (result.green == '0) && (result.blue == '0))
    // An unknown status never lights the LED.
    `LSP_ASSERT_NOW(a_unknown_dark, clk, rst_n, done && !result.recognized, !result.lit)

endmodule

// ----- tb/led_status_pattern_generator_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the status LED pattern generator.
//
// Every accepted beat is run through a behavioral predictor that works out
// the LED color from the status code and the elapsed time. The prediction is
// queued. Each result strobe is compared field by field with the oldest entry
// in that queue. The block has no configuration registers and keeps no state
// between beats, so the predictor holds none either.
//
// The stimulus has a directed part and a random part. The directed part
// covers the breathing peaks and wrap points, the blink edges, the timeouts,
// the dark states, unknown codes and start times that lie after the current
// time. The random part sends bursts of beats with random gaps. Most of the
// elapsed times are short or sit on a pattern boundary, so every branch is
// reached often.
module led_status_pattern_generator_tb;

    localparam int CLK_PERIOD_NS  = 20;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_BEATS   = 1300;
    // The longest quiet stretch in a correct run is a sender gap plus the
    // pipeline latency. The limit below is many times that.
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = lsp_pkg::LATENCY + 5;

    // Pattern timing in milliseconds.
    localparam int unsigned WRITE_PERIOD_MS = 500;
    localparam int unsigned WRITE_ON_MS     = 250;
    localparam int unsigned COMPLETE_MS     = 2000;
    localparam int unsigned ERROR_WINDOW_MS = 1200;
    localparam int unsigned ERROR_STEP_MS   = 200;
    localparam int unsigned MAX_LEVEL       = 255;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    lsp_pkg::lsp_in_t   item = '0;
    logic               done;
    lsp_pkg::lsp_out_t  result;

    // Predicted colors of the beats that are still in the pipeline.
    lsp_pkg::lsp_out_t expected_colors[$];
    int       mismatch_count = 0;
    int       quiet_cycles = 0;

    led_status_pattern_generator dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    // Scales one color channel by a brightness level, rounding to nearest.
    function automatic logic [7:0] dim_channel(input logic [7:0] full, input int unsigned level);
        int unsigned scaled;
        scaled = (full * level + 127) / MAX_LEVEL;
        return scaled[7:0];
    endfunction

    // Works out the LED color that one beat must produce.
    function automatic lsp_pkg::lsp_out_t predict_led_color(input lsp_pkg::lsp_in_t beat);
        logic [31:0] elapsed;
        int unsigned cycle_ms;
        int unsigned half_ms;
        int unsigned phase_ms;
        int unsigned ramp_ms;
        int unsigned floor_level;
        int unsigned level;
        logic [7:0]  base_r;
        logic [7:0]  base_g;
        logic [7:0]  base_b;
        bit          breathing;
        lsp_pkg::lsp_out_t color_out;

        // The elapsed time wraps, so a start time after now gives a huge value.
        elapsed = beat.now_ms - beat.state_start_ms;
        color_out = '0;
        color_out.recognized = 1'b1;
        breathing = 1'b0;
        cycle_ms = 1;
        floor_level = 0;
        {base_r, base_g, base_b} = '0;

        case (beat.led_state)
            lsp_pkg::ST_GENERATING:
            begin
                {base_r, base_g, base_b} = {8'd0, 8'd255, 8'd60};
                cycle_ms = 2000;
                floor_level = 48;
                breathing = 1'b1;
            end
            lsp_pkg::ST_DOWNLOADING:
            begin
                {base_r, base_g, base_b} = {8'd0, 8'd90, 8'd255};
                cycle_ms = 600;
                floor_level = 64;
                breathing = 1'b1;
            end
            lsp_pkg::ST_CACHING:
            begin
                {base_r, base_g, base_b} = {8'd255, 8'd190, 8'd0};
                cycle_ms = 800;
                floor_level = 64;
                breathing = 1'b1;
            end
            lsp_pkg::ST_CONVERTING:
            begin
                {base_r, base_g, base_b} = {8'd0, 8'd220, 8'd160};
                cycle_ms = 1000;
                floor_level = 56;
                breathing = 1'b1;
            end
            lsp_pkg::ST_WRITING:
            begin
                if ((elapsed % WRITE_PERIOD_MS) < WRITE_ON_MS)
                begin
                    {color_out.red, color_out.green, color_out.blue} = {8'd255, 8'd120, 8'd0};
                    color_out.lit = 1'b1;
                end
            end
            lsp_pkg::ST_COMPLETE:
            begin
                if (elapsed < COMPLETE_MS)
                begin
                    {color_out.red, color_out.green, color_out.blue} = {8'd0, 8'd255, 8'd60};
                    color_out.lit = 1'b1;
                end
            end
            lsp_pkg::ST_ERROR:
            begin
                if (elapsed < ERROR_WINDOW_MS && ((elapsed / ERROR_STEP_MS) % 2) == 0)
                begin
                    {color_out.red, color_out.green, color_out.blue} = {8'd255, 8'd0, 8'd0};
                    color_out.lit = 1'b1;
                end
            end
            lsp_pkg::ST_OFF:
            begin
                // Known status, dark LED.
            end
            default:
            begin
                color_out.recognized = 1'b0;
            end
        endcase

        // Triangle wave: up from the floor to full brightness over the first
        // half of the period and back down over the second half.
        if (breathing)
        begin
            half_ms = cycle_ms / 2;
            phase_ms = elapsed % cycle_ms;
            ramp_ms = (phase_ms <= half_ms) ? phase_ms : cycle_ms - phase_ms;
            level = floor_level + ((MAX_LEVEL - floor_level) * ramp_ms) / half_ms;
            color_out.red = dim_channel(base_r, level);
            color_out.green = dim_channel(base_g, level);
            color_out.blue = dim_channel(base_b, level);
            color_out.lit = 1'b1;
        end
        return color_out;
    endfunction

    // Offers one beat and holds it until the block takes it. start is left
    // high so that a following beat can go out in the next cycle.
    task automatic send_beat(input lsp_pkg::lsp_in_t beat);
        start <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_colors.push_back(predict_led_color(beat));
    endtask

    // Sends a status that began elapsed_ms before the current time.
    task automatic send_status(input logic [3:0] code, input logic [31:0] start_ms,
                               input logic [31:0] elapsed_ms);
        lsp_pkg::lsp_in_t beat;
        beat.led_state = code;
        beat.state_start_ms = start_ms;
        beat.now_ms = start_ms + elapsed_ms;
        send_beat(beat);
    endtask

    // Drops start for a number of cycles. The item lines carry junk meanwhile,
    // which the block must ignore.
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            item <= {4'($urandom()), $urandom(), $urandom()};
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic test_breathing_peaks();
        // The top of each triangle, the bottom of the first, and steps next to a top or across a period.
        send_status(lsp_pkg::ST_GENERATING, $urandom(), 32'd0);
        send_status(lsp_pkg::ST_GENERATING, $urandom(), 32'd1000);
        send_status(lsp_pkg::ST_DOWNLOADING, $urandom(), 32'd299);
        send_status(lsp_pkg::ST_DOWNLOADING, $urandom(), 32'd300);
        send_status(lsp_pkg::ST_CACHING, $urandom(), 32'd400);
        send_status(lsp_pkg::ST_CACHING, $urandom(), 32'd799);
        send_status(lsp_pkg::ST_CONVERTING, $urandom(), 32'd500);
        send_status(lsp_pkg::ST_CONVERTING, $urandom(), 32'd1001);
    endtask

    task automatic test_blink_edges();
        send_status(lsp_pkg::ST_WRITING, $urandom(), 32'd249);
        send_status(lsp_pkg::ST_WRITING, $urandom(), 32'd250);
        send_status(lsp_pkg::ST_ERROR, $urandom(), 32'd199);
        send_status(lsp_pkg::ST_ERROR, $urandom(), 32'd200);
        send_status(lsp_pkg::ST_ERROR, $urandom(), 32'd800);
        send_status(lsp_pkg::ST_ERROR, $urandom(), 32'd1200);
    endtask

    task automatic test_complete_timeout();
        send_status(lsp_pkg::ST_COMPLETE, $urandom(), 32'd1999);
        send_status(lsp_pkg::ST_COMPLETE, $urandom(), 32'd2000);
    endtask

    task automatic test_dark_and_unknown();
        send_status(lsp_pkg::ST_OFF, $urandom(), 32'd0);
        send_status(4'd8, $urandom(), 32'd0);
        send_status(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_time_extremes();
        // Start times after now make the elapsed time wrap to a huge value.
        send_status(lsp_pkg::ST_GENERATING, 32'd0, 32'hFFFF_FFFF);
        send_status(lsp_pkg::ST_WRITING, 32'hFFFF_FFFF, 32'd1);
        send_status(lsp_pkg::ST_COMPLETE, 32'd20, 32'hFFFF_FFF6);
    endtask

    task automatic test_random_patterns();
        logic [3:0]  code;
        logic [31:0] elapsed_ms;
        int          pick;
        int          burst_left;

        burst_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // Bursts of back-to-back beats with random gaps between them. A few
            // bursts are long, giving stretches with no idling at all.
            if (burst_left == 0)
            begin
                hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
            end
            burst_left--;

            code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                elapsed_ms = $urandom_range(0, 4000);
            else if (pick < 80)
                // Every period, half period, blink and timeout is a multiple
                // of 50 ms, so this lands on or next to a boundary.
                elapsed_ms = $urandom_range(1, 100) * 50 + $urandom_range(0, 2) - 1;
            else if (pick < 92)
                elapsed_ms = $urandom();
            else
                elapsed_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            send_status(code, $urandom(), elapsed_ms);
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] expected,
                                input logic [7:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Each strobe must match the oldest outstanding prediction.
    always @(posedge clk)
    begin
        lsp_pkg::lsp_out_t predicted;
        if (rst_n && done === 1'b1)
        begin
            if (expected_colors.size() == 0)
            begin
                $display("%0t: result with no beat outstanding, got %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                predicted = expected_colors.pop_front();
                report_field("recognized", 8'(predicted.recognized), 8'(result.recognized));
                report_field("red", predicted.red, result.red);
                report_field("green", predicted.green, result.green);
                report_field("blue", predicted.blue, result.blue);
                report_field("lit", 8'(predicted.lit), 8'(result.lit));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither a beat nor a result
    // moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_breathing_peaks();
        test_blink_edges();
        test_complete_timeout();
        test_dark_and_unknown();
        test_time_extremes();
        test_random_patterns();
        start <= 1'b0;

        // Let the pipeline drain, then watch a little longer for stray strobes.
        wait (expected_colors.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_colors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
